FILE: design/swipe_gesture_classifier_core_defines.svh
// Assertion macros shared by the swipe gesture classifier RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef SWIPE_GESTURE_CLASSIFIER_CORE_DEFINES_SVH
`define SWIPE_GESTURE_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SGC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/sgc_pkg.sv
// Shared types and constants for the swipe gesture classifier.
// No dependencies; used by sgc_step and swipe_gesture_classifier_core.
package sgc_pkg;

   localparam int ACC_WIDTH = 24;                  // signed Q16.8 accumulator
   localparam int DELTA_WIDTH = 16;                // signed Q8.8 motion delta
   localparam int THR_WIDTH = 16;                  // unsigned Q8.8 threshold
   localparam int THR_SQ_WIDTH = 2 * THR_WIDTH;    // threshold squared
   localparam int SQ_WIDTH = 2 * ACC_WIDTH;        // one squared magnitude
   localparam int DIST_WIDTH = SQ_WIDTH + 1;       // sum of two squares
   localparam int SCALED_WIDTH = DIST_WIDTH + 7;   // 100 times the distance
   localparam int CODE_WIDTH = 3;

   localparam logic [3:0] FOUR_FINGERS = 4'd4;

   // Gesture code bit positions.
   localparam int CODE_FOUR_BIT = 0;
   localparam int CODE_POS_BIT = 1;
   localparam int CODE_VERT_BIT = 2;

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_UPDATE = 2'd1,
      CMD_END = 2'd2
   } cmd_type;

   typedef struct packed {
      logic signed [ACC_WIDTH-1:0] sum_x;
      logic signed [ACC_WIDTH-1:0] sum_y;
      logic [CODE_WIDTH-1:0] last_code;
      logic is_fresh;
      logic in_gesture;
   } state_type;

   typedef struct packed {
      logic emit;
      logic [CODE_WIDTH-1:0] code;
   } result_type;

endpackage

FILE: design/sgc_step.sv
// Single-pass evaluation of one swipe transaction: next state and optional code.
// Depends on sgc_pkg.
module sgc_step (
   input  sgc_pkg::state_type                   cur_state,
   input  logic [1:0]                           command,
   input  logic [3:0]                           finger_count,
   input  logic signed [sgc_pkg::DELTA_WIDTH-1:0] delta_x,
   input  logic signed [sgc_pkg::DELTA_WIDTH-1:0] delta_y,
   input  logic [sgc_pkg::THR_SQ_WIDTH-1:0]     thr_sq,
   output sgc_pkg::state_type                   next_state,
   output sgc_pkg::result_type                  result
);

   // Saturating add of a sign-extended delta into an accumulator.
   function automatic logic signed [sgc_pkg::ACC_WIDTH-1:0] sat_add(
      input logic signed [sgc_pkg::ACC_WIDTH-1:0] acc,
      input logic signed [sgc_pkg::DELTA_WIDTH-1:0] d
   );
      logic [sgc_pkg::ACC_WIDTH:0] wide;
      wide = {acc[sgc_pkg::ACC_WIDTH-1], acc}
           + {{(sgc_pkg::ACC_WIDTH + 1 - sgc_pkg::DELTA_WIDTH){d[sgc_pkg::DELTA_WIDTH-1]}}, d};
      if (wide[sgc_pkg::ACC_WIDTH] != wide[sgc_pkg::ACC_WIDTH-1]) begin
         sat_add = wide[sgc_pkg::ACC_WIDTH]
                 ? {1'b1, {(sgc_pkg::ACC_WIDTH-1){1'b0}}}
                 : {1'b0, {(sgc_pkg::ACC_WIDTH-1){1'b1}}};
      end else begin
         sat_add = wide[sgc_pkg::ACC_WIDTH-1:0];
      end
   endfunction

   logic signed [sgc_pkg::ACC_WIDTH-1:0] new_x;
   logic signed [sgc_pkg::ACC_WIDTH-1:0] new_y;
   logic [sgc_pkg::ACC_WIDTH-1:0]        ux;
   logic [sgc_pkg::ACC_WIDTH-1:0]        uy;
   logic [sgc_pkg::ACC_WIDTH-1:0]        ax;
   logic [sgc_pkg::ACC_WIDTH-1:0]        ay;
   logic [sgc_pkg::SQ_WIDTH-1:0]         sq_x;
   logic [sgc_pkg::SQ_WIDTH-1:0]         sq_y;
   logic [sgc_pkg::DIST_WIDTH-1:0]       dist_sum;
   logic [sgc_pkg::SCALED_WIDTH-1:0]     dist_ext;
   logic [sgc_pkg::SCALED_WIDTH-1:0]     dist_x100;
   logic                                 crossed;
   logic                                 horiz;
   logic [sgc_pkg::CODE_WIDTH-1:0]       code;
   logic [sgc_pkg::CODE_WIDTH-1:0]       opposite;
   logic                                 emit;

   assign new_x = sat_add(cur_state.sum_x, delta_x);
   assign new_y = sat_add(cur_state.sum_y, delta_y);

   // Magnitudes; the most negative sum maps to 2^(ACC_WIDTH-1), still in range.
   assign ux = new_x;
   assign uy = new_y;
   assign ax = ux[sgc_pkg::ACC_WIDTH-1] ? (~ux + sgc_pkg::ACC_WIDTH'(1)) : ux;
   assign ay = uy[sgc_pkg::ACC_WIDTH-1] ? (~uy + sgc_pkg::ACC_WIDTH'(1)) : uy;

   assign sq_x = ax * ax;
   assign sq_y = ay * ay;
   assign dist_sum = sgc_pkg::DIST_WIDTH'(sq_x) + sgc_pkg::DIST_WIDTH'(sq_y);

   // 100 * dist_sum as shifted adds (64 + 32 + 4).
   assign dist_ext = sgc_pkg::SCALED_WIDTH'(dist_sum);
   assign dist_x100 = (dist_ext << 6) + (dist_ext << 5) + (dist_ext << 2);

   assign crossed = cur_state.is_fresh
                  ? (dist_sum > sgc_pkg::DIST_WIDTH'(thr_sq))
                  : (dist_x100 > sgc_pkg::SCALED_WIDTH'(thr_sq));

   assign horiz = ax > ay;

   always_comb begin
      code = '0;
      code[sgc_pkg::CODE_FOUR_BIT] = (finger_count == sgc_pkg::FOUR_FINGERS);
      code[sgc_pkg::CODE_VERT_BIT] = !horiz;
      code[sgc_pkg::CODE_POS_BIT] = horiz ? !new_x[sgc_pkg::ACC_WIDTH-1]
                                          : !new_y[sgc_pkg::ACC_WIDTH-1];
   end

   always_comb begin
      opposite = cur_state.last_code;
      opposite[sgc_pkg::CODE_POS_BIT] = !cur_state.last_code[sgc_pkg::CODE_POS_BIT];
   end

   assign emit = crossed && (cur_state.is_fresh || code == opposite);

   always_comb begin
      next_state = cur_state;
      result.emit = 1'b0;
      result.code = code;
      unique case (sgc_pkg::cmd_type'(command))
         sgc_pkg::CMD_BEGIN: begin
            if (!cur_state.in_gesture) begin
               next_state.in_gesture = 1'b1;
               next_state.is_fresh = 1'b1;
               next_state.sum_x = '0;
               next_state.sum_y = '0;
            end
         end
         sgc_pkg::CMD_UPDATE: begin
            if (cur_state.in_gesture) begin
               if (emit) begin
                  next_state.sum_x = '0;
                  next_state.sum_y = '0;
                  next_state.last_code = code;
                  next_state.is_fresh = 1'b0;
                  result.emit = 1'b1;
               end else begin
                  next_state.sum_x = new_x;
                  next_state.sum_y = new_y;
               end
            end
         end
         sgc_pkg::CMD_END: begin
            next_state.in_gesture = 1'b0;
         end
         default: begin
            // reserved command: hold everything
         end
      endcase
   end

endmodule

FILE: design/swipe_gesture_classifier_core.sv
// Swipe gesture classifier top level: input register, state, result register.
// Depends on sgc_pkg, sgc_step and swipe_gesture_classifier_core_defines.svh.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------------
//   req     | in        | req_valid / req_ready  | command, finger_count, delta_x, delta_y
//   rsp     | out       | rsp_valid / rsp_ready  | gesture_code
//   csr     | in        | csr_write_enable       | threshold (csr_write_data)
//
// One transaction per cycle sustained while rsp is not stalled. A transaction is
// held in the input register, then a single pass (saturating add, two squarers,
// scaled compare) updates the gesture state and, when the step emits a code, loads
// the result register that drives rsp.
// Synchronous active-high reset clears the state, the threshold and both valid flags.
// A stalled rsp channel holds the result; the input register still takes one more
// transaction, then req_ready drops until the result is taken.
`include "swipe_gesture_classifier_core_defines.svh"

module swipe_gesture_classifier_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_command,
   input  logic [3:0]                             req_finger_count,
   input  logic signed [sgc_pkg::DELTA_WIDTH-1:0] req_delta_x,
   input  logic signed [sgc_pkg::DELTA_WIDTH-1:0] req_delta_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [sgc_pkg::CODE_WIDTH-1:0]         rsp_gesture_code,
   input  logic                                   csr_write_enable,
   input  logic [sgc_pkg::THR_WIDTH-1:0]          csr_write_data
);

   // Input register.
   logic                                   in_valid_ff;
   logic                                   in_valid_in;
   logic [1:0]                             in_command_ff;
   logic [3:0]                             in_fingers_ff;
   logic signed [sgc_pkg::DELTA_WIDTH-1:0] in_dx_ff;
   logic signed [sgc_pkg::DELTA_WIDTH-1:0] in_dy_ff;

   // Gesture state and threshold squared (squared once at write time).
   sgc_pkg::state_type                     state_ff;
   sgc_pkg::state_type                     state_in;
   logic [sgc_pkg::THR_SQ_WIDTH-1:0]       thr_sq_ff;
   logic [sgc_pkg::THR_SQ_WIDTH-1:0]       thr_sq_in;

   // Result register.
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic [sgc_pkg::CODE_WIDTH-1:0]         rsp_code_ff;

   sgc_pkg::result_type                    step_result;
   logic                                   take_req;
   logic                                   out_free;
   logic                                   fire;

   // Advance the held transaction whenever the result register can take a code.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fire = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || fire;
   assign take_req = req_valid && req_ready;

   sgc_step u_step (
      .cur_state    (state_ff),
      .command      (in_command_ff),
      .finger_count (in_fingers_ff),
      .delta_x      (in_dx_ff),
      .delta_y      (in_dy_ff),
      .thr_sq       (thr_sq_ff),
      .next_state   (state_in),
      .result       (step_result)
   );

   assign in_valid_in = take_req || (in_valid_ff && !fire);
   // Drop the shown code once taken; load a new one only when the step emits.
   assign rsp_valid_in = fire ? step_result.emit : (rsp_valid_ff && !rsp_ready);
   assign thr_sq_in = csr_write_enable
                    ? sgc_pkg::THR_SQ_WIDTH'(csr_write_data)
                      * sgc_pkg::THR_SQ_WIDTH'(csr_write_data)
                    : thr_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_sq_ff <= '0;
         state_ff.sum_x <= '0;
         state_ff.sum_y <= '0;
         state_ff.last_code <= '0;
         state_ff.is_fresh <= 1'b1;
         state_ff.in_gesture <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_sq_ff <= thr_sq_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_command_ff <= req_command;
         in_fingers_ff <= req_finger_count;
         in_dx_ff <= req_delta_x;
         in_dy_ff <= req_delta_y;
      end
      if (fire && step_result.emit) begin
         rsp_code_ff <= step_result.code;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_gesture_code = rsp_code_ff;

   // An emitted code is remembered as the last code and ends freshness.
   `SGC_ASSERT_NEXT(a_emit_records_code, clock, reset, fire && step_result.emit, !state_ff.is_fresh && state_ff.last_code == rsp_code_ff && rsp_valid_ff, "emitted code not recorded in state")
   // Codes are only produced inside a gesture.
   `SGC_ASSERT_NOW(a_emit_in_gesture, clock, reset, fire && step_result.emit, state_ff.in_gesture, "code emitted outside a gesture")
   // Emitting clears both accumulators.
   `SGC_ASSERT_NEXT(a_emit_clears_sums, clock, reset, fire && step_result.emit, state_ff.sum_x == '0 && state_ff.sum_y == '0, "accumulators not cleared on emit")
   // An empty input register always accepts.
   `SGC_ASSERT_NOW(a_empty_ready, clock, reset, !in_valid_ff, req_ready, "input register empty but not ready")

endmodule
